### hdl/clqm_pkg.sv
// Shared definitions for the circular linked queue manager.
// Default sizes, fixed field widths, request op codes and status codes.
// No dependencies.
package clqm_pkg;

    localparam int NUM_ELEMS_DEF  = 64;
    localparam int NUM_QUEUES_DEF = 4;

    localparam int OP_W = 2;
    localparam int ST_W = 3;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_SIZE   = 2'd2;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_IN_THIS  = 3'd1;
    localparam logic [ST_W-1:0] ST_IN_OTHER = 3'd2;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [ST_W-1:0] ST_IN_NONE  = 3'd4;
    localparam logic [ST_W-1:0] ST_NOT_THIS = 3'd5;

endpackage

### hdl/clqm_if.sv
// Valid/ready channels of the queue manager: request and response.
// Depends on clqm_pkg for default sizes and field widths.
interface clqm_req_if
    import clqm_pkg::*;
#(
    parameter int QW = (NUM_QUEUES_DEF > 1) ? $clog2(NUM_QUEUES_DEF) : 1,
    parameter int EW = $clog2(NUM_ELEMS_DEF)
);
    logic            valid;
    logic            ready;
    logic [OP_W-1:0] op;
    logic [QW-1:0]   queue_id;
    logic [EW-1:0]   elem_id;

    modport source (output valid, output op, output queue_id, output elem_id, input ready);
    modport sink   (input valid, input op, input queue_id, input elem_id, output ready);
endinterface

interface clqm_rsp_if
    import clqm_pkg::*;
#(
    parameter int EW = $clog2(NUM_ELEMS_DEF),
    parameter int CW = $clog2(NUM_ELEMS_DEF + 1)
);
    logic            valid;
    logic            ready;
    logic [ST_W-1:0] status;
    logic [CW-1:0]   count;
    logic [EW-1:0]   head_elem;

    modport source (output valid, output status, output count, output head_elem, input ready);
    modport sink   (input valid, input status, input count, input head_elem, output ready);
endinterface

### hdl/circular_linked_queue_manager_core.sv
// A request is taken only in the idle state; its result is registered once the
// response register is free. An append to a non-empty queue then also passes
// through the link and fix states (two more writes into the link memories).
// Reset: a clearing pass over max(NUM_ELEMS, NUM_QUEUES) addresses zeroes the owner
// and queue memories; no request is taken until it ends.
// Depends on clqm_pkg and the channel interfaces in clqm_if.sv.
module circular_linked_queue_manager_core
    import clqm_pkg::*;
#(
    parameter int NUM_ELEMS  = NUM_ELEMS_DEF,
    parameter int NUM_QUEUES = NUM_QUEUES_DEF
)(
    input  logic       clk,
    input  logic       rst_n,
    clqm_req_if.sink   req,
    clqm_rsp_if.source rsp
);

    localparam int E_W    = $clog2(NUM_ELEMS);
    localparam int Q_W    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int C_W    = $clog2(NUM_ELEMS + 1);
    localparam int CLR_N  = (NUM_ELEMS > NUM_QUEUES) ? NUM_ELEMS : NUM_QUEUES;
    localparam int CLR_W  = $clog2(CLR_N);

    localparam logic [E_W:0]     ELEMS_E   = (E_W + 1)'(NUM_ELEMS);
    localparam logic [Q_W:0]     QUEUES_Q  = (Q_W + 1)'(NUM_QUEUES);
    localparam logic [CLR_W:0]   ELEMS_C   = (CLR_W + 1)'(NUM_ELEMS);
    localparam logic [CLR_W:0]   QUEUES_C  = (CLR_W + 1)'(NUM_QUEUES);
    localparam logic [CLR_W-1:0] CLR_LAST  = CLR_W'(CLR_N - 1);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_LNK  = 3'd3;
    localparam logic [2:0] S_FIX  = 3'd4;

    typedef struct packed {
        logic           linked;
        logic [Q_W-1:0] owner;
    } own_t;

    typedef struct packed {
        logic [C_W-1:0] cnt;
        logic [E_W-1:0] head;
    } qent_t;

    logic [E_W-1:0] nxt_mem [NUM_ELEMS];
    logic [E_W-1:0] prv_mem [NUM_ELEMS];
    own_t           own_mem [NUM_ELEMS];
    qent_t          q_mem   [NUM_QUEUES];

    logic [2:0]       state_reg, state_next;
    logic [CLR_W-1:0] clr_reg, clr_next;
    logic [OP_W-1:0]  op_reg, op_next;
    logic [Q_W-1:0]   q_reg, q_next;
    logic [E_W-1:0]   e_reg, e_next;
    logic [E_W-1:0]   hd_reg, hd_next;

    logic            out_valid_reg, out_valid_next;
    logic [ST_W-1:0] status_reg;
    logic [C_W-1:0]  count_reg;
    logic [E_W-1:0]  head_out_reg;

    logic [E_W-1:0] e_in;
    logic [Q_W-1:0] q_in;

    logic           rd_re;
    logic           prv_re;
    logic [E_W-1:0] prv_ra;
    logic [E_W-1:0] nxt_rd, prv_rd;
    own_t           own_rd;
    qent_t          q_rd;

    logic           nxt_we, prv_we, own_we, q_we;
    logic [E_W-1:0] nxt_wa, nxt_wd, prv_wa, prv_wd, own_wa;
    logic [Q_W-1:0] q_wa;
    own_t           own_wd;
    qent_t          q_wd;

    logic            out_free, emit;
    logic [ST_W-1:0] st_res;
    logic [C_W-1:0]  cnt_res;
    logic [E_W-1:0]  hd_res;

    assign e_in = ({1'b0, req.elem_id} >= ELEMS_E) ?
                  E_W'(req.elem_id - E_W'(NUM_ELEMS)) : req.elem_id;
    assign q_in = ({1'b0, req.queue_id} >= QUEUES_Q) ?
                  Q_W'(req.queue_id - Q_W'(NUM_QUEUES)) : req.queue_id;

    assign req.ready = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk)
    begin
        if (nxt_we)
        begin
            nxt_mem[nxt_wa] <= nxt_wd;
        end
        if (rd_re)
        begin
            nxt_rd <= nxt_mem[e_in];
        end
    end

    always_ff @(posedge clk)
    begin
        if (prv_we)
        begin
            prv_mem[prv_wa] <= prv_wd;
        end
        if (prv_re)
        begin
            prv_rd <= prv_mem[prv_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (own_we)
        begin
            own_mem[own_wa] <= own_wd;
        end
        if (rd_re)
        begin
            own_rd <= own_mem[e_in];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[q_wa] <= q_wd;
        end
        if (rd_re)
        begin
            q_rd <= q_mem[q_in];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        op_next    = op_reg;
        q_next     = q_reg;
        e_next     = e_reg;
        hd_next    = hd_reg;

        rd_re  = 1'b0;
        prv_re = 1'b0;
        prv_ra = e_in;

        nxt_we = 1'b0;
        nxt_wa = e_reg;
        nxt_wd = hd_reg;
        prv_we = 1'b0;
        prv_wa = e_reg;
        prv_wd = prv_rd;
        own_we = 1'b0;
        own_wa = e_reg;
        own_wd = '{linked: 1'b1, owner: q_reg};
        q_we   = 1'b0;
        q_wa   = q_reg;
        q_wd   = q_rd;

        emit    = 1'b0;
        st_res  = ST_OK;
        cnt_res = q_rd.cnt;
        hd_res  = q_rd.head;

        case (state_reg)
            S_CLR:
            begin
                own_we = ({1'b0, clr_reg} < ELEMS_C);
                own_wa = clr_reg[E_W-1:0];
                own_wd = '0;
                q_we   = ({1'b0, clr_reg} < QUEUES_C);
                q_wa   = clr_reg[Q_W-1:0];
                q_wd   = '0;
                if (clr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + CLR_W'(1);
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    rd_re      = 1'b1;
                    prv_re     = 1'b1;
                    prv_ra     = e_in;
                    op_next    = req.op;
                    q_next     = q_in;
                    e_next     = e_in;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    case (op_reg)
                        OP_APPEND:
                        begin
                            if (own_rd.linked)
                            begin
                                st_res = (own_rd.owner == q_reg) ? ST_IN_THIS : ST_IN_OTHER;
                            end
                            else
                            begin
                                own_we  = 1'b1;
                                q_we    = 1'b1;
                                nxt_we  = 1'b1;
                                cnt_res = q_rd.cnt + C_W'(1);
                                q_wd.cnt = cnt_res;
                                if (q_rd.cnt == '0)
                                begin
                                    nxt_wd    = e_reg;
                                    prv_we    = 1'b1;
                                    prv_wd    = e_reg;
                                    q_wd.head = e_reg;
                                    hd_res    = e_reg;
                                end
                                else
                                begin
                                    nxt_wd     = q_rd.head;
                                    prv_re     = 1'b1;
                                    prv_ra     = q_rd.head;
                                    hd_next    = q_rd.head;
                                    state_next = S_LNK;
                                end
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (q_rd.cnt == '0)
                            begin
                                st_res = ST_EMPTY;
                            end
                            else if (!own_rd.linked)
                            begin
                                st_res = ST_IN_NONE;
                            end
                            else if (own_rd.owner != q_reg)
                            begin
                                st_res = ST_NOT_THIS;
                            end
                            else
                            begin
                                own_we   = 1'b1;
                                own_wd   = '{linked: 1'b0, owner: q_reg};
                                q_we     = 1'b1;
                                cnt_res  = q_rd.cnt - C_W'(1);
                                q_wd.cnt = cnt_res;
                                if (q_rd.cnt != C_W'(1))
                                begin
                                    nxt_we = 1'b1;
                                    nxt_wa = prv_rd;
                                    nxt_wd = nxt_rd;
                                    prv_we = 1'b1;
                                    prv_wa = nxt_rd;
                                    prv_wd = prv_rd;
                                    if (q_rd.head == e_reg)
                                    begin
                                        q_wd.head = nxt_rd;
                                        hd_res    = nxt_rd;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            st_res = ST_OK;
                        end
                    endcase
                end
            end
            S_LNK:
            begin
                nxt_we     = 1'b1;
                nxt_wa     = prv_rd;
                nxt_wd     = e_reg;
                prv_we     = 1'b1;
                prv_wa     = e_reg;
                prv_wd     = prv_rd;
                state_next = S_FIX;
            end
            S_FIX:
            begin
                prv_we     = 1'b1;
                prv_wa     = hd_reg;
                prv_wd     = e_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        q_reg  <= q_next;
        e_reg  <= e_next;
        hd_reg <= hd_next;
        if (emit)
        begin
            status_reg   <= st_res;
            count_reg    <= cnt_res;
            head_out_reg <= (cnt_res != '0) ? hd_res : '0;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = status_reg;
    assign rsp.count     = count_reg;
    assign rsp.head_elem = head_out_reg;

endmodule
